>>> design/dspb_pkg.sv
// shared types, widths and constants of the directional sparkle pixel blend
`timescale 1ns / 1ps

package dspb_pkg;

    // coordinate bits of col_idx and row_idx that take part in the geometry
    localparam int COORD_BITS    = 12;
    localparam int COORD_FIELD_W = 12;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int POS_W      = 16;
    localparam int TRIG_W     = 16;
    localparam int RECIP_W    = 17;
    localparam int TINT_W     = NUM_CH * CH_W;
    localparam int GAIN_W     = 10;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // geometry widths
    localparam int SCALED_W   = COORD_BITS + 4;
    localparam int DX_W       = ((SCALED_W > POS_W) ? SCALED_W : POS_W) + 1;
    localparam int ROT_W      = DX_W + TRIG_W + 1;
    localparam int NPROD_W    = ROT_W + RECIP_W;
    localparam int NORM_SHIFT = 18;
    localparam int NORM_W     = NPROD_W - NORM_SHIFT;
    localparam int FRAC_W     = 16;
    localparam int WT_W       = FRAC_W + 1;

    // blend widths
    localparam int TW_W       = CH_W + WT_W;
    localparam int ADD_PROD_W = TW_W + GAIN_W;
    localparam int ADD_SHIFT  = 24;
    localparam int ADD_W      = ADD_PROD_W - ADD_SHIFT;
    localparam int SUM_W      = ADD_W + 1;

    localparam logic [DX_W-1:0]  COORD_MASK = DX_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [WT_W-1:0]  ONE_Q16    = WT_W'(64'd1 << FRAC_W);
    localparam logic [CH_W-1:0]  CH_MAX     = '1;

    // pipeline depths
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int MAX_INFLIGHT = FRONT_STAGES + QUEUE_DEPTH + BACK_STAGES;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_COS_DIR      = 3'd2,
        REG_SIN_DIR      = 3'd3,
        REG_ALONG_RECIP  = 3'd4,
        REG_ACROSS_RECIP = 3'd5,
        REG_TINT_RGB     = 3'd6,
        REG_GAIN         = 3'd7
    } cfg_idx_t;

    localparam logic [POS_W-1:0]   RST_CENTER_X     = 16'd32768;
    localparam logic [POS_W-1:0]   RST_CENTER_Y     = 16'd32768;
    localparam logic [TRIG_W-1:0]  RST_COS_DIR      = 16'd16384;
    localparam logic [TRIG_W-1:0]  RST_SIN_DIR      = 16'd0;
    localparam logic [RECIP_W-1:0] RST_ALONG_RECIP  = 17'd65536;
    localparam logic [RECIP_W-1:0] RST_ACROSS_RECIP = 17'd5958;
    localparam logic [TINT_W-1:0]  RST_TINT_RGB     = 24'hFFFFFF;
    localparam logic [GAIN_W-1:0]  RST_GAIN         = 10'd256;

    typedef logic [CH_W-1:0] chan_t;
    // channel 2 red, 1 green, 0 blue, same order as the tint word
    typedef chan_t [NUM_CH-1:0] rgb_t;

    typedef struct packed {
        logic [POS_W-1:0]          center_x;
        logic [POS_W-1:0]          center_y;
        logic signed [TRIG_W-1:0]  cos_dir;
        logic signed [TRIG_W-1:0]  sin_dir;
        logic [RECIP_W-1:0]        along_recip;
        logic [RECIP_W-1:0]        across_recip;
        logic [TINT_W-1:0]         tint;
        logic [GAIN_W-1:0]         gain;
    } cfg_t;

    typedef struct packed {
        logic [COORD_FIELD_W-1:0] col;
        logic [COORD_FIELD_W-1:0] row;
        rgb_t                     rgb;
    } pixel_t;

    // classified item handed from the front to the back
    typedef struct packed {
        rgb_t            rgb;
        logic            hit;
        logic [WT_W-1:0] wa;
        logic [WT_W-1:0] wc;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic chan_t sat_add(input chan_t base, input logic [ADD_W-1:0] add);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(add);
        return (sum > SUM_W'(CH_MAX)) ? CH_MAX : sum[CH_W-1:0];
    endfunction

endpackage

>>> design/dspb_front.sv
// front end: offset, rotation, normalisation and streak box classification
`timescale 1ns / 1ps

module dspb_front
    import dspb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  pixel_t      in_pix,
    output logic        push,
    output queue_item_t push_item,
    input  q_status_t   q_status
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv;

    logic [DX_W-1:0]         col_m, row_m;
    logic signed [DX_W-1:0]  dx_next, dy_next, dx_reg, dy_reg;
    rgb_t                    rgb1_reg, rgb2_reg, rgb3_reg;

    logic signed [ROT_W-1:0] along_next, across_next, along_reg, across_reg;

    logic [ROT_W-1:0]        along_mag, across_mag;
    logic [NPROD_W-1:0]      an_prod, cn_prod;
    logic [NORM_W-1:0]       an_next, cn_next, an_reg, cn_reg;

    // stall only when the last stage holds an item the queue cannot take
    assign adv      = !(v3_reg && q_status.full);
    assign in_ready = adv;

    always_comb
    begin
        col_m   = DX_W'(in_pix.col) & COORD_MASK;
        row_m   = DX_W'(in_pix.row) & COORD_MASK;
        dx_next = $signed((col_m << 4) - DX_W'(cfg.center_x));
        dy_next = $signed((row_m << 4) - DX_W'(cfg.center_y));
    end

    always_comb
    begin
        along_next  = dx_reg * cfg.cos_dir + dy_reg * cfg.sin_dir;
        across_next = dy_reg * cfg.cos_dir - dx_reg * cfg.sin_dir;
    end

    always_comb
    begin
        along_mag  = along_reg[ROT_W-1] ? ROT_W'(-along_reg) : ROT_W'(along_reg);
        across_mag = across_reg[ROT_W-1] ? ROT_W'(-across_reg) : ROT_W'(across_reg);
        an_prod    = NPROD_W'(along_mag) * NPROD_W'(cfg.along_recip);
        cn_prod    = NPROD_W'(across_mag) * NPROD_W'(cfg.across_recip);
        an_next    = an_prod[NPROD_W-1:NORM_SHIFT];
        cn_next    = cn_prod[NPROD_W-1:NORM_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            rgb1_reg   <= in_pix.rgb;
            along_reg  <= along_next;
            across_reg <= across_next;
            rgb2_reg   <= rgb1_reg;
            an_reg     <= an_next;
            cn_reg     <= cn_next;
            rgb3_reg   <= rgb2_reg;
        end
    end

    // inside the box when both normalised distances are below one
    always_comb
    begin
        push           = v3_reg && !q_status.full;
        push_item.rgb  = rgb3_reg;
        push_item.hit  = (an_reg[NORM_W-1:FRAC_W] == '0) && (cn_reg[NORM_W-1:FRAC_W] == '0);
        push_item.wa   = ONE_Q16 - WT_W'(an_reg[FRAC_W-1:0]);
        push_item.wc   = ONE_Q16 - WT_W'(cn_reg[FRAC_W-1:0]);
    end

endmodule

>>> design/dspb_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps

module dspb_queue
    import dspb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_item_t push_item,
    input  logic        pop,
    output queue_item_t pop_item,
    output q_status_t   q_status
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    queue_item_t         store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    assign pop_item       = store_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

>>> design/dspb_back.sv
// back end: weight product, tint and gain scaling, saturating add
`timescale 1ns / 1ps

module dspb_back
    import dspb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_status_t   q_status,
    output logic        pop,
    input  queue_item_t pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output rgb_t        out_rgb,
    output logic        out_hit
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv;

    logic [2*WT_W-1:0]   w_prod;
    logic [WT_W-1:0]     w_reg;
    rgb_t                rgb1_reg, rgb2_reg, rgb3_reg, rgb4_reg;
    logic                hit1_reg, hit2_reg, hit3_reg, hit4_reg;

    logic [TW_W-1:0]       tw_next [NUM_CH];
    logic [TW_W-1:0]       tw_reg  [NUM_CH];
    logic [ADD_PROD_W-1:0] add_prod [NUM_CH];
    logic [ADD_W-1:0]      add_reg [NUM_CH];
    rgb_t                  rgb_next;

    assign adv = !v4_reg || out_ready;
    assign pop = adv && !q_status.empty;

    always_comb
    begin
        w_prod = (2*WT_W)'(pop_item.wa) * (2*WT_W)'(pop_item.wc);
        for (int c = 0; c < NUM_CH; c++)
        begin
            tw_next[c]  = TW_W'(cfg.tint[c*CH_W +: CH_W]) * TW_W'(w_reg);
            add_prod[c] = ADD_PROD_W'(tw_reg[c]) * ADD_PROD_W'(cfg.gain);
        end
        // outside the box the pixel passes through
        for (int c = 0; c < NUM_CH; c++)
            rgb_next[c] = hit3_reg ? sat_add(rgb3_reg[c], add_reg[c]) : rgb3_reg[c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= !q_status.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg    <= w_prod[FRAC_W+WT_W-1:FRAC_W];
            rgb1_reg <= pop_item.rgb;
            hit1_reg <= pop_item.hit;
            for (int c = 0; c < NUM_CH; c++)
            begin
                tw_reg[c]  <= tw_next[c];
                add_reg[c] <= add_prod[c][ADD_PROD_W-1:ADD_SHIFT];
            end
            rgb2_reg <= rgb1_reg;
            hit2_reg <= hit1_reg;
            rgb3_reg <= rgb2_reg;
            hit3_reg <= hit2_reg;
            rgb4_reg <= rgb_next;
            hit4_reg <= hit3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_rgb   = rgb4_reg;
    assign out_hit   = hit4_reg;

endmodule

>>> design/directional_sparkle_pixel_blend_top.sv
// top level of the directional sparkle pixel blend
`timescale 1ns / 1ps

// directional sparkle pixel blend: takes one pixel item per clock (column, row,
// rgb) and adds a tinted streak to it. the offset from the configured centre
// is rotated by the configured direction, each axis is scaled by its
// reciprocal, and inside the unit box every channel gets
// tint * (1-along) * (1-across) * gain added, truncated and saturated at 255;
// touched (m_tuser) flags those pixels. sustained rate is one item per clock
// while m_tready stays high. on its way to m_tvalid an item passes three
// front stages (offset, rotation, normalisation multiply), the four-entry
// queue, four back stages (weight, tint, gain, saturating add). the 34 by 17 bit
// normalisation multiply sets the critical path. s_tready falls only when the
// queue is full and the front holds a finished item, so the front keeps going
// while a result waits on m_tready. config registers are written through
// cfg_we / cfg_addr / cfg_wdata and should only change while no item is in
// flight. no clearing pass is needed after reset.

module directional_sparkle_pixel_blend_top
    import dspb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // col_idx, row_idx, red_in, green_in, blue_in
    // result item
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tuser,   // touched
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    pixel_t      in_pix;
    logic        push, pop;
    queue_item_t push_item, pop_item;
    q_status_t   q_status;
    rgb_t        out_rgb;
    logic        out_hit;

    // register file, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= RST_CENTER_X;
            cfg_reg.center_y     <= RST_CENTER_Y;
            cfg_reg.cos_dir      <= RST_COS_DIR;
            cfg_reg.sin_dir      <= RST_SIN_DIR;
            cfg_reg.along_recip  <= RST_ALONG_RECIP;
            cfg_reg.across_recip <= RST_ACROSS_RECIP;
            cfg_reg.tint         <= RST_TINT_RGB;
            cfg_reg.gain         <= RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_CENTER_X:     cfg_reg.center_x     <= cfg_wdata[POS_W-1:0];
                REG_CENTER_Y:     cfg_reg.center_y     <= cfg_wdata[POS_W-1:0];
                REG_COS_DIR:      cfg_reg.cos_dir      <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_DIR:      cfg_reg.sin_dir      <= cfg_wdata[TRIG_W-1:0];
                REG_ALONG_RECIP:  cfg_reg.along_recip  <= cfg_wdata[RECIP_W-1:0];
                REG_ACROSS_RECIP: cfg_reg.across_recip <= cfg_wdata[RECIP_W-1:0];
                REG_TINT_RGB:     cfg_reg.tint         <= cfg_wdata[TINT_W-1:0];
                REG_GAIN:         cfg_reg.gain         <= cfg_wdata[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // unpack input item, channel 2 is red
    always_comb
    begin
        in_pix.col    = s_tdata[11:0];
        in_pix.row    = s_tdata[23:12];
        in_pix.rgb[2] = s_tdata[31:24];
        in_pix.rgb[1] = s_tdata[39:32];
        in_pix.rgb[0] = s_tdata[47:40];
    end

    dspb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .push      (push),
        .push_item (push_item),
        .q_status  (q_status)
    );

    dspb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    dspb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop       (pop),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (out_rgb),
        .out_hit   (out_hit)
    );

    // pack result item
    assign m_tdata = {out_rgb[0], out_rgb[1], out_rgb[2]};
    assign m_tuser = out_hit;

endmodule

>>> design/dspb_checker.sv
// port level checks of the directional sparkle pixel blend, bound to the top level
`timescale 1ns / 1ps

module dspb_checker
    import dspb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser
);

    localparam int CNT_W = $clog2(MAX_INFLIGHT + 1) + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg != '0)
        else $error("result item without an outstanding input item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_INFLIGHT))
        else $error("more items in flight than the pipeline holds");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> cnt_reg >= CNT_W'(QUEUE_DEPTH + 1))
        else $error("input stalled while the queue had room");

endmodule

bind directional_sparkle_pixel_blend_top dspb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
// self-checking testbench for the directional sparkle pixel blend top level
`timescale 1ns / 1ps

import dspb_pkg::*;

// one blended pixel as it leaves the block
typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  touched;
} blend_px_t;

// shadow of the config registers plus the queue of predicted blended pixels
class sparkle_scoreboard;
    cfg_t      regs;
    blend_px_t blend_q[$];
    int        errors;

    function new();
        regs.center_x     = RST_CENTER_X;
        regs.center_y     = RST_CENTER_Y;
        regs.cos_dir      = RST_COS_DIR;
        regs.sin_dir      = RST_SIN_DIR;
        regs.along_recip  = RST_ALONG_RECIP;
        regs.across_recip = RST_ACROSS_RECIP;
        regs.tint         = RST_TINT_RGB;
        regs.gain         = RST_GAIN;
        errors            = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CENTER_X:     regs.center_x     = val[POS_W-1:0];
            REG_CENTER_Y:     regs.center_y     = val[POS_W-1:0];
            REG_COS_DIR:      regs.cos_dir      = val[TRIG_W-1:0];
            REG_SIN_DIR:      regs.sin_dir      = val[TRIG_W-1:0];
            REG_ALONG_RECIP:  regs.along_recip  = val[RECIP_W-1:0];
            REG_ACROSS_RECIP: regs.across_recip = val[RECIP_W-1:0];
            REG_TINT_RGB:     regs.tint         = val[TINT_W-1:0];
            REG_GAIN:         regs.gain         = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // saturating add of tint * weight * gain
    function chan_t sparkle_chan(chan_t base, logic [CH_W-1:0] tint_c, longint wt);
        longint add_v;
        longint sum_v;
        add_v = (longint'(tint_c) * wt * longint'(regs.gain)) >>> 24;
        sum_v = longint'(base) + add_v;
        return (sum_v > 255) ? CH_MAX : chan_t'(sum_v);
    endfunction

    function blend_px_t predict_blend(pixel_t px);
        logic signed [TRIG_W-1:0] c16;
        logic signed [TRIG_W-1:0] s16;
        longint c, s, dx, dy, along, across, an, cn, wt, cmask;
        blend_px_t res;
        c16    = regs.cos_dir;
        s16    = regs.sin_dir;
        c      = c16;
        s      = s16;
        // only the low coordinate bits take part
        cmask  = (longint'(1) << COORD_BITS) - 1;
        dx     = (longint'(px.col) & cmask) * 16 - longint'(regs.center_x);
        dy     = (longint'(px.row) & cmask) * 16 - longint'(regs.center_y);
        along  = dx * c + dy * s;
        across = dy * c - dx * s;
        if (along < 0)
            along = -along;
        if (across < 0)
            across = -across;
        an = (along * longint'(regs.along_recip)) >>> 18;
        cn = (across * longint'(regs.across_recip)) >>> 18;
        res.red     = px.rgb[2];
        res.green   = px.rgb[1];
        res.blue    = px.rgb[0];
        res.touched = 1'b0;
        if (an < 65536 && cn < 65536)
        begin
            wt          = ((65536 - an) * (65536 - cn)) >>> 16;
            res.red     = sparkle_chan(px.rgb[2], regs.tint[23:16], wt);
            res.green   = sparkle_chan(px.rgb[1], regs.tint[15:8], wt);
            res.blue    = sparkle_chan(px.rgb[0], regs.tint[7:0], wt);
            res.touched = 1'b1;
        end
        return res;
    endfunction

    function void note_pixel(pixel_t px);
        blend_q.push_back(predict_blend(px));
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void cmp_field(string name, int want, int got);
        if (want != got)
            note_error($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_result(blend_px_t got);
        blend_px_t want;
        if (blend_q.size() == 0)
        begin
            note_error($sformatf("unexpected item rgb %0d %0d %0d touched %0d",
                                 got.red, got.green, got.blue, got.touched));
            return;
        end
        want = blend_q.pop_front();
        cmp_field("red_out", want.red, got.red);
        cmp_field("green_out", want.green, got.green);
        cmp_field("blue_out", want.blue, got.blue);
        cmp_field("touched", want.touched, got.touched);
    endfunction
endclass

module tb;

    // settle a bit longer than the block takes from accept to result
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_addr  = REG_CENTER_X;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sparkle_scoreboard sb;

    // knobs shared by the stimulus and the receiver
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_off_req = 1'b0;
    int cycle_count  = 0;

    directional_sparkle_pixel_blend_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // watchdog, reckoned far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[directional_sparkle_pixel_blend_top] ERROR");
            $finish;
        end
    end

    // result checker: an item moves when m_tvalid and m_tready are both high
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{red: m_tdata[7:0], green: m_tdata[15:8],
                              blue: m_tdata[23:16], touched: m_tuser});
    end

    // receiver: random stalls, mostly short, some long, plus one long hold-off
    // that backs the block up until s_tready drops
    initial
    begin : rx_side
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left == 0 && run_left == 0 && !rx_steady)
            begin
                run_left = $urandom_range(0, 24);
                if ($urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(8, 60);
                else
                    stall_left = $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    // sender gap before the next item
    function automatic int next_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic pixel_t mk_pixel(int col, int row, int r, int g, int b);
        pixel_t px;
        px.col    = col[COORD_FIELD_W-1:0];
        px.row    = row[COORD_FIELD_W-1:0];
        px.rgb[2] = r[CH_W-1:0];
        px.rgb[1] = g[CH_W-1:0];
        px.rgb[0] = b[CH_W-1:0];
        return px;
    endfunction

    // mostly pixels around the streak centre at a random spread, the rest
    // anywhere in the frame
    function automatic pixel_t pick_pixel();
        pixel_t px;
        int     spread;
        int     base_c;
        int     base_r;
        int     ext;
        if ($urandom_range(0, 3) == 0)
        begin
            px.col = COORD_FIELD_W'($urandom_range(0, 4095));
            px.row = COORD_FIELD_W'($urandom_range(0, 4095));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       spread = 1;
                1:       spread = 4;
                2:       spread = 16;
                3:       spread = 64;
                default: spread = 256;
            endcase
            base_c = int'(sb.regs.center_x >> 4) - spread;
            base_r = int'(sb.regs.center_y >> 4) - spread;
            px.col = COORD_FIELD_W'(base_c + int'($urandom_range(0, 2 * spread)));
            px.row = COORD_FIELD_W'(base_r + int'($urandom_range(0, 2 * spread)));
        end
        if ($urandom_range(0, 6) == 0)
        begin
            ext    = ($urandom_range(0, 1) == 1) ? 255 : 0;
            px.rgb = {3{ext[CH_W-1:0]}};
        end
        else
        begin
            px.rgb[2] = CH_W'($urandom_range(0, 255));
            px.rgb[1] = CH_W'($urandom_range(0, 255));
            px.rgb[0] = CH_W'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // offer one pixel item; valid stays high straight into the next item
    // when there is no gap
    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        // tdata: col_idx, row_idx, red_in, green_in, blue_in from bit 0 up
        s_tdata  <= {px.rgb[0], px.rgb[1], px.rgb[2], px.row, px.col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel(px);
    endtask

    // stop offering and wait until every predicted pixel has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.blend_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                               input logic [TRIG_W-1:0] cs, input logic [TRIG_W-1:0] sn,
                               input logic [RECIP_W-1:0] ar, input logic [RECIP_W-1:0] cr,
                               input logic [TINT_W-1:0] tint, input logic [GAIN_W-1:0] gn);
        write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(REG_COS_DIR, CFG_DATA_W'(cs));
        write_reg(REG_SIN_DIR, CFG_DATA_W'(sn));
        write_reg(REG_ALONG_RECIP, CFG_DATA_W'(ar));
        write_reg(REG_ACROSS_RECIP, CFG_DATA_W'(cr));
        write_reg(REG_TINT_RGB, CFG_DATA_W'(tint));
        write_reg(REG_GAIN, CFG_DATA_W'(gn));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // direction component: mostly within +-1.0, sometimes any 16-bit pattern
    function automatic logic [TRIG_W-1:0] rand_trig();
        if ($urandom_range(0, 9) == 0)
            return TRIG_W'($urandom);
        return TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // reciprocal of a half size of 1 to 300 pixels, sometimes zero or raw
    function automatic logic [RECIP_W-1:0] rand_recip();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return RECIP_W'($urandom);
        return RECIP_W'(65536 / $urandom_range(1, 300));
    endfunction

    task automatic run_pixels(input int n_items, input bit steady);
        tx_steady = steady;
        rx_steady = steady;
        repeat (n_items) send_pixel(pick_pixel());
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [GAIN_W-1:0] gn;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: centre pixel (2048, 2048), box 1 px along, ~11 px across
        send_pixel(mk_pixel(2048, 2048, 0, 0, 0));        // full weight
        send_pixel(mk_pixel(2048, 2048, 255, 255, 255));  // saturation
        send_pixel(mk_pixel(2048, 2048, 128, 1, 254));
        send_pixel(mk_pixel(2049, 2048, 10, 20, 30));     // along on the box edge
        send_pixel(mk_pixel(2047, 2048, 10, 20, 30));
        send_pixel(mk_pixel(2048, 2058, 40, 50, 60));     // just inside across
        send_pixel(mk_pixel(2048, 2059, 40, 50, 60));     // just outside across
        send_pixel(mk_pixel(2048, 2038, 70, 80, 90));
        send_pixel(mk_pixel(2048, 2037, 70, 80, 90));
        send_pixel(mk_pixel(2048, 2045, 200, 100, 50));
        send_pixel(mk_pixel(0, 0, 0, 0, 0));              // frame corners
        send_pixel(mk_pixel(4095, 4095, 255, 255, 255));
        send_pixel(mk_pixel(0, 4095, 1, 2, 3));
        send_pixel(mk_pixel(4095, 0, 253, 254, 255));
        send_pixel(mk_pixel(0, 2048, 9, 9, 9));
        send_pixel(mk_pixel(4095, 2048, 9, 9, 9));
        send_pixel(mk_pixel(2048, 0, 9, 9, 9));
        send_pixel(mk_pixel(2048, 4095, 9, 9, 9));
        run_pixels(150, 1'b0);

        // everything zero: zero reciprocals hit every pixel, nothing is added
        load_config('0, '0, '0, '0, '0, '0, '0, '0);
        run_pixels(100, 1'b0);

        // every register at its top pattern, well beyond the documented range
        load_config('1, '1, 16'h7FFF, 16'h8000, '1, '1, '1, '1);
        run_pixels(150, 1'b0);

        // reversed direction, zero along reciprocal, double brightness
        load_config(16'd12345, 16'd54321, 16'hC000, '0, '0, 17'd65536,
                    TINT_W'($urandom), 10'd512);
        run_pixels(150, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            gn = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                             : GAIN_W'($urandom_range(0, 512));
            load_config(POS_W'($urandom), POS_W'($urandom), rand_trig(), rand_trig(),
                        rand_recip(), rand_recip(), TINT_W'($urandom), gn);
            // one phase with the output held off long enough to fill the block
            if (p == 2)
                hold_off_req = 1'b1;
            run_pixels(170, (p == 2) || (p == 5));
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.blend_q.size() == 0)
            $display("[directional_sparkle_pixel_blend_top] OK");
        else
            $display("[directional_sparkle_pixel_blend_top] ERROR");
        $finish;
    end

endmodule

>>> directional_sparkle_pixel_blend_top.f
design/dspb_pkg.sv
design/dspb_front.sv
design/dspb_queue.sv
design/dspb_back.sv
design/directional_sparkle_pixel_blend_top.sv
design/dspb_checker.sv
tb/tb.sv
